@@ sv/oriented_box_inflater_defines.svh @@
// Assertion macros used by the oriented box inflater checker.
`ifndef ORIENTED_BOX_INFLATER_DEFINES_SVH
`define ORIENTED_BOX_INFLATER_DEFINES_SVH

// Checked at every rising clock edge while reset is released.
`define OBI_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) prop) else $error(msg);

// Checked at every rising clock edge, reset included.
`define OBI_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ sv/obi_pkg.sv @@
// Types, constants and stage functions of the oriented box inflater pipeline.
package obi_pkg;

    localparam int NUM_COORDS = 8;
    localparam int NUM_DIFFS  = 8;
    localparam int SQ_STEPS   = 33;
    localparam int DIV_STEPS  = 54;

    localparam int ST_MUL   = 1;
    localparam int ST_SUM   = 2;
    localparam int ST_SQ0   = 3;
    localparam int ST_PREP  = ST_SQ0 + SQ_STEPS;
    localparam int ST_DIV0  = ST_PREP + 1;
    localparam int ST_OUT   = ST_DIV0 + DIV_STEPS;
    localparam int NSTG     = ST_OUT + 1;

    localparam logic [19:0] MARGIN_RESET = 20'd19661;

    // Corner differences: minuend and subtrahend coordinate indexes.
    localparam int DA [NUM_DIFFS] = '{0, 1, 4, 5, 0, 1, 2, 3};
    localparam int DB [NUM_DIFFS] = '{2, 3, 6, 7, 6, 7, 4, 5};
    // Differences whose squares form the two side lengths.
    localparam int SQ_SRC [4] = '{0, 1, 4, 5};
    // Offset terms of each output coordinate and whether the difference is flipped.
    localparam int T1 [NUM_COORDS] = '{0, 1, 0, 1, 2, 3, 2, 3};
    localparam int T2 [NUM_COORDS] = '{4, 5, 6, 7, 6, 7, 4, 5};
    localparam logic [7:0] F1 = 8'b1100_1100;
    localparam logic [7:0] F2 = 8'b1111_0000;

    typedef struct packed {
        logic [7:0][31:0] corner;
        logic [7:0]       neg;
        logic [7:0][31:0] mag;
        logic [3:0][63:0] sq;
        logic [7:0][51:0] prod;
        logic [1:0][65:0] rad;
        logic [1:0][35:0] rem;
        logic [1:0][32:0] root;
        logic [1:0][33:0] den;
        logic [1:0]       zero;
        logic [7:0][53:0] num;
        logic [7:0][34:0] drem;
        logic [7:0][53:0] quo;
        logic [7:0][31:0] res;
        logic             degen;
    } item_t;

    function automatic item_t entry_fn(input logic [255:0] d);
        item_t n;
        logic signed [32:0] df;
        n = '0;
        for (int i = 0; i < NUM_COORDS; i++) begin
            n.corner[i] = d[32*i +: 32];
        end
        for (int i = 0; i < NUM_DIFFS; i++) begin
            df = 33'(signed'(n.corner[DA[i]])) - 33'(signed'(n.corner[DB[i]]));
            n.neg[i] = df[32];
            n.mag[i] = df[32] ? 32'(-df) : df[31:0];
        end
        return n;
    endfunction

    function automatic item_t stage_fn(input item_t p, input int idx, input logic [19:0] mg);
        item_t n;
        logic [35:0] r36;
        logic [35:0] t36;
        logic [34:0] r35;
        logic [53:0] q1;
        logic [53:0] q2;
        logic signed [55:0] acc;
        int k;
        int j;
        int l;
        n = p;
        if (idx == ST_MUL) begin
            for (int i = 0; i < 4; i++) begin
                n.sq[i] = 64'(p.mag[SQ_SRC[i]]) * 64'(p.mag[SQ_SRC[i]]);
            end
            for (int i = 0; i < NUM_DIFFS; i++) begin
                n.prod[i] = 52'(p.mag[i]) * 52'(mg);
            end
        end else if (idx == ST_SUM) begin
            for (int i = 0; i < 2; i++) begin
                n.rad[i]  = 66'(p.sq[2*i]) + 66'(p.sq[2*i+1]);
                n.rem[i]  = '0;
                n.root[i] = '0;
            end
        end else if (idx >= ST_SQ0 && idx < ST_PREP) begin
            k = SQ_STEPS - 1 - (idx - ST_SQ0);
            for (int i = 0; i < 2; i++) begin
                r36 = {p.rem[i][33:0], p.rad[i][2*k +: 2]};
                t36 = {1'b0, p.root[i], 2'b01};
                if (r36 >= t36) begin
                    n.rem[i]  = r36 - t36;
                    n.root[i] = {p.root[i][31:0], 1'b1};
                end else begin
                    n.rem[i]  = r36;
                    n.root[i] = {p.root[i][31:0], 1'b0};
                end
            end
        end else if (idx == ST_PREP) begin
            for (int i = 0; i < 2; i++) begin
                n.den[i]  = {p.root[i], 1'b0};
                n.zero[i] = (p.root[i] == '0);
            end
            for (int i = 0; i < NUM_DIFFS; i++) begin
                l = (i < 4) ? 0 : 1;
                n.num[i]  = {1'b0, p.prod[i], 1'b0} + 54'(p.root[l]);
                n.drem[i] = '0;
                n.quo[i]  = '0;
            end
            n.degen = (p.root[0] == '0) || (p.root[1] == '0);
        end else if (idx >= ST_DIV0 && idx < ST_OUT) begin
            j = DIV_STEPS - 1 - (idx - ST_DIV0);
            for (int i = 0; i < NUM_DIFFS; i++) begin
                l = (i < 4) ? 0 : 1;
                r35 = {p.drem[i][33:0], p.num[i][j]};
                if (r35 >= {1'b0, p.den[l]}) begin
                    n.drem[i] = r35 - {1'b0, p.den[l]};
                    n.quo[i]  = {p.quo[i][52:0], 1'b1};
                end else begin
                    n.drem[i] = r35;
                    n.quo[i]  = {p.quo[i][52:0], 1'b0};
                end
            end
        end else if (idx == ST_OUT) begin
            for (int o = 0; o < NUM_COORDS; o++) begin
                q1  = p.zero[0] ? '0 : p.quo[T1[o]];
                q2  = p.zero[1] ? '0 : p.quo[T2[o]];
                acc = 56'(signed'(p.corner[o]));
                if (p.neg[T1[o]] ^ F1[o]) begin
                    acc = acc - signed'({2'b00, q1});
                end else begin
                    acc = acc + signed'({2'b00, q1});
                end
                if (p.neg[T2[o]] ^ F2[o]) begin
                    acc = acc - signed'({2'b00, q2});
                end else begin
                    acc = acc + signed'({2'b00, q2});
                end
                if (acc > 56'sd2147483647) begin
                    n.res[o] = 32'h7FFF_FFFF;
                end else if (acc < -56'sd2147483648) begin
                    n.res[o] = 32'h8000_0000;
                end else begin
                    n.res[o] = acc[31:0];
                end
            end
        end
        return n;
    endfunction

endpackage

@@ sv/oriented_box_inflater.sv @@
// Top level of the oriented box inflater: a fully pipelined corner grower.
//
// Channel   Direction  Payload
// s_        in         s_tdata: a_x, a_y, b_x, b_y, c_x, c_y, d_x, d_y
// m_        out        m_tdata: grown_a_x .. grown_d_y, m_tuser: degenerate
// cfg_      in         cfg_data: margin
//
// One box is taken every cycle while the output is not stalled.
// Most of the pipeline is made up of the 33-step square root and the 54-step divider stages.
// Reset clears all stage valid bits and loads the default margin.
// A stalled output holds the whole pipeline; nothing is lost or repeated.
module oriented_box_inflater (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [255:0] s_tdata,   // a_x, a_y, b_x, b_y, c_x, c_y, d_x, d_y
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [255:0] m_tdata,   // grown_a_x, grown_a_y, ..., grown_d_x, grown_d_y
    output logic         m_tuser,   // degenerate
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [19:0]  cfg_data
);
    import obi_pkg::*;

    item_t       pipe_reg  [NSTG];
    item_t       pipe_next [NSTG];
    logic [NSTG-1:0] vld_reg;
    logic [19:0] margin_reg;
    logic        adv;

    assign adv       = !vld_reg[NSTG-1] || m_tready;
    assign s_tready  = adv;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            margin_reg <= MARGIN_RESET;
        end else if (cfg_valid) begin
            margin_reg <= cfg_data;
        end
    end

    assign pipe_next[0] = entry_fn(s_tdata);

    for (genvar i = 1; i < NSTG; i++) begin : g_stage
        assign pipe_next[i] = stage_fn(pipe_reg[i-1], i, margin_reg);
    end

    for (genvar i = 0; i < NSTG; i++) begin : g_reg
        always_ff @(posedge aclk) begin
            if (adv) begin
                pipe_reg[i] <= pipe_next[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[NSTG-2:0], s_tvalid};
        end
    end

    assign m_tvalid = vld_reg[NSTG-1];
    assign m_tdata  = pipe_reg[NSTG-1].res;
    assign m_tuser  = pipe_reg[NSTG-1].degen;

endmodule

@@ sv/obi_checker.sv @@
// Port-level assertions for the oriented box inflater, bound to its top level.
`include "oriented_box_inflater_defines.svh"

module obi_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [255:0] m_tdata,
    input logic         m_tuser
);

    `OBI_ASSERT(a_hold_valid, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid, "result dropped while stalled")
    `OBI_ASSERT(a_hold_data, aclk, aresetn, m_tvalid && !m_tready |=> $stable({m_tuser, m_tdata}), "result changed while stalled")
    `OBI_ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_tvalid, "result valid after reset")
    `OBI_ASSERT(a_ready_rule, aclk, aresetn, s_tready == (!m_tvalid || m_tready), "input ready does not follow output stall")

endmodule

bind oriented_box_inflater obi_checker u_obi_checker (.*);

@@ test/tb_top.sv @@
// Testbench for the oriented box inflater: directed and random boxes checked against a predictor.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY = 92;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct {
        logic [7:0][31:0] corner;
        logic             degen;
    } grown_box_t;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [255:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [255:0] m_tdata;
    logic         m_tuser;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [19:0]  cfg_data;

    logic [19:0]  cur_margin;
    grown_box_t   pending_boxes[$];
    int           error_count;
    int           boxes_sent;
    int           boxes_checked;
    int           degen_seen;
    int           idle_cycles;
    bit           long_hold;
    bit           hold_done;

    oriented_box_inflater dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    initial begin
        aclk = 0;
        forever #2 aclk = ~aclk;
    end

    function automatic logic [63:0] mag64(input longint d);
        return d < 0 ? 64'(-d) : 64'(d);
    endfunction

    function automatic logic [63:0] side_length(input longint dx, input longint dy);
        logic [65:0] rad;
        logic [67:0] rem;
        logic [67:0] trial;
        logic [63:0] root;
        rad = 66'(mag64(dx) * mag64(dx)) + 66'(mag64(dy) * mag64(dy));
        rem = 0;
        root = 0;
        for (int k = 32; k >= 0; k--) begin
            rem = (rem << 2) | 68'(rad[2*k +: 2]);
            trial = {2'b0, root, 2'b01};
            if (rem >= trial) begin
                rem = rem - trial;
                root = (root << 1) | 1;
            end else begin
                root = root << 1;
            end
        end
        return root;
    endfunction

    function automatic longint scaled_offset(input longint diff, input logic [63:0] len);
        logic [63:0] p;
        logic [63:0] q;
        if (len == 0) return 0;
        p = mag64(diff) * 64'(cur_margin);
        q = (2 * p + len) / (2 * len);
        return diff < 0 ? -longint'(q) : longint'(q);
    endfunction

    function automatic logic [31:0] clamp32(input longint v);
        if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
        if (v < -64'sd2147483648) return 32'h8000_0000;
        return v[31:0];
    endfunction

    function automatic grown_box_t inflate_box(input logic [255:0] d);
        grown_box_t g;
        longint c[8];
        logic [63:0] lab;
        logic [63:0] lad;
        for (int i = 0; i < 8; i++) c[i] = longint'(signed'(d[32*i +: 32]));
        lab = side_length(c[0] - c[2], c[1] - c[3]);
        lad = side_length(c[0] - c[6], c[1] - c[7]);
        for (int a = 0; a < 2; a++) begin
            g.corner[0+a] = clamp32(c[0+a] + scaled_offset(c[0+a] - c[2+a], lab)
                                    + scaled_offset(c[0+a] - c[6+a], lad));
            g.corner[2+a] = clamp32(c[2+a] + scaled_offset(c[2+a] - c[0+a], lab)
                                    + scaled_offset(c[2+a] - c[4+a], lad));
            g.corner[4+a] = clamp32(c[4+a] + scaled_offset(c[4+a] - c[6+a], lab)
                                    + scaled_offset(c[4+a] - c[2+a], lad));
            g.corner[6+a] = clamp32(c[6+a] + scaled_offset(c[6+a] - c[4+a], lab)
                                    + scaled_offset(c[6+a] - c[0+a], lad));
        end
        g.degen = (lab == 0) || (lad == 0);
        return g;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch at box %0d: %s got %h expected %h", boxes_checked, what, got, want);
        error_count++;
    endtask

    task automatic wait_cycles(input int n);
        repeat (n) @(negedge aclk);
    endtask

    task automatic write_margin(input logic [19:0] value);
        cfg_valid <= 1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cur_margin = value;
        @(negedge aclk);
        cfg_valid <= 0;
    endtask

    task automatic send_box(input logic [255:0] d, input bit gaps);
        int gap;
        gap = gaps ? $urandom_range(0, 13) : 0;
        if (gap > 0) begin
            s_tvalid <= 0;
            wait_cycles(gap);
        end
        s_tvalid <= 1;
        s_tdata  <= d;
        do @(posedge aclk); while (!s_tready);
        pending_boxes.insert(pending_boxes.size(), inflate_box(d));
        boxes_sent++;
        @(negedge aclk);
    endtask

    task automatic drain_pipe();
        s_tvalid <= 0;
        while (pending_boxes.size() != 0) @(negedge aclk);
        wait_cycles(LATENCY + 4);
    endtask

    function automatic logic [31:0] rand_coord(input int mode);
        case (mode)
            0: return $urandom;
            1: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
            default: return 32'($signed($urandom_range(0, 200)) - 100) <<< 16;
        endcase
    endfunction

    function automatic logic [255:0] rand_box();
        logic [255:0] d;
        int mode;
        int kind;
        logic signed [31:0] ax, ay, ux, uy, sc;
        mode = $urandom_range(0, 9);
        kind = $urandom_range(0, 9);
        if (kind < 6) begin
            ax = rand_coord(mode < 3 ? 2 : 1);
            ay = rand_coord(mode < 3 ? 2 : 1);
            ux = $signed($urandom_range(0, 400000)) - 200000;
            uy = $signed($urandom_range(0, 400000)) - 200000;
            sc = $urandom_range(0, 3);
            d[31:0] = ax;            d[63:32] = ay;
            d[95:64] = ax + ux;      d[127:96] = ay + uy;
            d[223:192] = ax - uy * sc;
            d[255:224] = ay + ux * sc;
            d[159:128] = d[95:64] - uy * sc;
            d[191:160] = d[127:96] + ux * sc;
        end else begin
            for (int i = 0; i < 8; i++) d[32*i +: 32] = rand_coord(mode % 3);
            if (kind == 9) begin
                d[95:64] = d[31:0];
                d[127:96] = d[63:32];
            end
        end
        return d;
    endfunction

    // Directed boxes: all-zero, rail extremes, degenerate sides, unit squares.
    localparam int NUM_DIRECTED = 10;
    logic [255:0] directed_boxes [NUM_DIRECTED] = '{
        256'h0,
        {8{32'h7FFF_FFFF}},
        {8{32'h8000_0000}},
        {32'h0001_0000, 32'h0000_0000, 32'h0001_0000, 32'h0001_0000,
         32'h0000_0000, 32'h0001_0000, 32'h0000_0000, 32'h0000_0000},
        {32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
         32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF},
        {32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
         32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000},
        {32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0001_0000,
         32'h0002_0000, 32'h0001_0000, 32'h0002_0000, 32'h0000_0000},
        {32'hFFFF_FFFF, 32'h0000_0001, 32'h5555_5555, 32'hAAAA_AAAA,
         32'h0000_0001, 32'hFFFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555},
        {32'h0000_0003, 32'h0000_0000, 32'h0000_0003, 32'h0000_0001,
         32'h0000_0000, 32'h0000_0001, 32'h0000_0000, 32'h0000_0000},
        {32'h7FFF_0000, 32'h7FFF_0000, 32'h7FFF_0000, 32'h7FFF_FFFF,
         32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_0000}
    };
    // Known results: an all-zero box and an all-equal box are degenerate and unchanged.
    bit directed_known [NUM_DIRECTED] = '{1, 1, 1, 0, 0, 0, 0, 0, 0, 0};

    logic [19:0] margin_steps [5] = '{20'd0, 20'd655360, 20'hFFFFF, 20'd1, 20'd65536};

    initial begin
        s_tvalid = 0; s_tdata = 0; cfg_valid = 0; cfg_data = 0;
        error_count = 0; boxes_sent = 0; boxes_checked = 0; degen_seen = 0;
        long_hold = 0; hold_done = 0;
        cur_margin = 20'd19661;
        aresetn = 0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1;

        for (int i = 0; i < NUM_DIRECTED; i++) begin
            send_box(directed_boxes[i], i[0]);
            if (directed_known[i]) begin
                pending_boxes[$].corner = directed_boxes[i];
                pending_boxes[$].degen  = 1;
            end
        end
        drain_pipe();

        for (int phase = 0; phase < 5; phase++) begin
            write_margin(margin_steps[phase]);
            for (int i = 0; i < 4; i++) send_box(directed_boxes[3 + 2 * i], 0);
            for (int i = 0; i < 240; i++) begin
                if (phase == 2 && i == 20) long_hold = 1;
                send_box(rand_box(), !(phase == 2 && i >= 20 && i < 140)
                         && !(phase == 3 && i < 60));
            end
            drain_pipe();
        end
        write_margin($urandom_range(0, 20'hFFFFF));
        for (int i = 0; i < 60; i++) send_box(rand_box(), 1);
        drain_pipe();

        $display("covered %0d boxes (%0d degenerate) over 7 margin settings",
                 boxes_sent, degen_seen);
        $display("input and output stalls, long output hold-off, drained pauses");
        if (error_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        int stall_len;
        m_tready = 0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (long_hold && !hold_done) begin
                m_tready <= 0;
                wait_cycles(300);
                hold_done = 1;
            end else if (boxes_sent > 1500 || $urandom_range(0, 3) == 0) begin
                m_tready <= 1;
            end else begin
                stall_len = $urandom_range(0, 13);
                if (stall_len == 0) begin
                    m_tready <= 1;
                end else begin
                    m_tready <= 0;
                    wait_cycles(stall_len);
                    m_tready <= 1;
                end
            end
        end
    end

    always @(posedge aclk) begin
        grown_box_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_boxes.size() == 0) begin
                $display("unexpected result transfer");
                error_count++;
            end else begin
                want = pending_boxes.pop_front();
                for (int i = 0; i < 8; i++)
                    if (m_tdata[32*i +: 32] !== want.corner[i])
                        report_mismatch($sformatf("coord %0d", i), m_tdata[32*i +: 32],
                                        want.corner[i]);
                if (m_tuser !== want.degen)
                    report_mismatch("degenerate", m_tuser, want.degen);
                degen_seen += want.degen;
                boxes_checked++;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
            || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("timeout with %0d results outstanding", pending_boxes.size());
                $display("== FAIL ==");
                $finish;
            end
        end
    end

endmodule
